FILE: rtl/core/kgc_pkg.sv
// Shared types, codes and constants for the key gesture classifier.
package kgc_pkg;

  // Field widths fixed by the request and event formats
  localparam int MODE_W = 2;
  localparam int KEY_W  = 4;
  localparam int AMT_W  = 8;
  localparam int KIND_W = 3;
  localparam int IDX_W  = 3;
  localparam int TIME_W = 32;
  localparam int HOLD_W = 16;

  // Defaults
  localparam int                NUM_KEYS_DEF  = 7;
  localparam logic [HOLD_W-1:0] HOLD_TIME_RST = 16'd500;

  // Special key numbers
  localparam logic [KEY_W-1:0] KEY_LEFT  = 4'd7;
  localparam logic [KEY_W-1:0] KEY_RIGHT = 4'd8;

  // Pair members
  localparam int TOP_A = 0;
  localparam int TOP_B = 3;
  localparam int BOT_A = 2;
  localparam int BOT_B = 5;

  // Request modes
  typedef enum logic [MODE_W-1:0] {
    MODE_PRESS   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_TURN    = 2'd2,
    MODE_TICK    = 2'd3
  } mode_t;

  // Event kinds
  typedef enum logic [KIND_W-1:0] {
    EV_CLICK      = 3'd0,
    EV_SIDE_CLICK = 3'd1,
    EV_SIDE_COMBO = 3'd2,
    EV_TOP_PAIR   = 3'd3,
    EV_BOT_PAIR   = 3'd4,
    EV_TURN       = 3'd5,
    EV_HOLD       = 3'd6
  } ev_kind_t;

  // One registered request
  typedef struct packed {
    mode_t                   mode;
    logic [KEY_W-1:0]        key;
    logic signed [AMT_W-1:0] amount;
  } req_t;

  // Classifier decision for one request
  typedef struct packed {
    logic                    fire;
    ev_kind_t                kind;
    logic [IDX_W-1:0]        index;
    logic signed [AMT_W-1:0] amount;
  } evt_t;

endpackage

FILE: rtl/core/key_gesture_classifier.sv
// Requests wait in the input register; events go out from the result register.
// Throughput: one request per cycle while the result register has space; a tick's
// hold check (stamp select, 32-bit subtract and compare) lies between the registers.
// A held event does not stop intake while a new request fits behind it.
// Reset (rst_n low, synchronous) clears key flags, timers, pairs, the ms counter
// and both stage valids, and sets hold_time to 500.
module key_gesture_classifier import kgc_pkg::*; #(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [HOLD_W-1:0]       cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [MODE_W-1:0]       in_mode,
  input  logic [KEY_W-1:0]        in_key,
  input  logic signed [AMT_W-1:0] in_turn_amount,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [KIND_W-1:0]       out_event_kind,
  output logic [IDX_W-1:0]        out_event_index,
  output logic signed [AMT_W-1:0] out_event_amount
);

  logic req_valid, space, go;
  req_t req;
  evt_t evt;

  // A request is classified when the result register can take its event
  assign go = req_valid && space;

  kgc_in_stage u_in (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_key         (in_key),
    .in_turn_amount (in_turn_amount),
    .take           (go),
    .req_valid      (req_valid),
    .req            (req)
  );

  kgc_core #(.NUM_KEYS(NUM_KEYS)) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .go          (go),
    .req         (req),
    .evt         (evt)
  );

  kgc_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .go               (go),
    .evt              (evt),
    .space            (space),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_event_index  (out_event_index),
    .out_event_amount (out_event_amount)
  );

endmodule

FILE: rtl/core/kgc_in_stage.sv
// Input register stage: holds one request until the classifier takes it.
module kgc_in_stage import kgc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [MODE_W-1:0]       in_mode,
  input  logic [KEY_W-1:0]        in_key,
  input  logic signed [AMT_W-1:0] in_turn_amount,
  input  logic                    take,
  output logic                    req_valid,
  output req_t                    req
);

  logic req_valid_r, req_valid_nxt;
  req_t req_r;
  logic load;

  // Free when empty or when the held request leaves this cycle
  assign in_ready = !req_valid_r || take;
  assign load     = in_valid && in_ready;

  always_comb begin
    req_valid_nxt = req_valid_r;
    if (load) begin
      req_valid_nxt = 1'b1;
    end else if (take) begin
      req_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      req_r.mode   <= mode_t'(in_mode);
      req_r.key    <= in_key;
      req_r.amount <= in_turn_amount;
    end
  end

  assign req_valid = req_valid_r;
  assign req       = req_r;

endmodule

FILE: rtl/core/kgc_core.sv
// Classifier: key state, hold timers, time counter and event decision.
module kgc_core import kgc_pkg::*; #(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [HOLD_W-1:0] cfg_wr_data,
  input  logic              go,
  input  req_t              req,
  output evt_t              evt
);

  localparam int KI_W = $clog2(NUM_KEYS);

  // State
  logic [HOLD_W-1:0]   hold_time_r;
  logic [NUM_KEYS-1:0] key_down_r, key_down_nxt;
  logic [NUM_KEYS-1:0] timer_on_r, timer_on_nxt;
  logic [NUM_KEYS-1:0] held_r, held_nxt;
  logic                pair_top_r, pair_top_nxt;
  logic                pair_bot_r, pair_bot_nxt;
  logic [1:0]          side_down_r, side_down_nxt;
  logic [TIME_W-1:0]   now_ms_r, now_ms_nxt;
  logic [TIME_W-1:0]   press_stamp_r [NUM_KEYS];

  // Decode
  logic                enc_key, side_key;
  logic [KI_W-1:0]     key_idx;
  logic [NUM_KEYS-1:0] key_oh;
  logic [1:0]          side_bit;
  logic                stamp_we;

  // Hold check
  logic                lone_key;
  logic [KI_W-1:0]     found;
  logic [TIME_W-1:0]   now_inc, elapsed;
  logic                hold_due;

  assign enc_key  = req.key < KEY_W'(NUM_KEYS);
  assign side_key = (req.key == KEY_LEFT) || (req.key == KEY_RIGHT);
  assign key_idx  = req.key[KI_W-1:0];
  assign key_oh   = enc_key ? ({{(NUM_KEYS-1){1'b0}}, 1'b1} << key_idx) : '0;
  assign side_bit = (req.key == KEY_RIGHT) ? 2'b10 : 2'b01;

  // Highest-numbered running timer
  always_comb begin
    found = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (timer_on_r[i]) begin
        found = KI_W'(i);
      end
    end
  end

  assign lone_key = (key_down_r != '0) && ((key_down_r & (key_down_r - 1'b1)) == '0);
  assign now_inc  = now_ms_r + 1'b1;
  assign elapsed  = now_inc - press_stamp_r[found];
  assign hold_due = lone_key && (timer_on_r != '0)
                    && (elapsed >= {{(TIME_W-HOLD_W){1'b0}}, hold_time_r});

  // Next state and event
  always_comb begin
    key_down_nxt  = key_down_r;
    timer_on_nxt  = timer_on_r;
    held_nxt      = held_r;
    pair_top_nxt  = pair_top_r;
    pair_bot_nxt  = pair_bot_r;
    side_down_nxt = side_down_r;
    now_ms_nxt    = now_ms_r;
    stamp_we      = 1'b0;
    evt.fire      = 1'b0;
    evt.kind      = EV_CLICK;
    evt.index     = '0;
    evt.amount    = '0;
    case (req.mode)
      MODE_PRESS: begin
        if (side_key) begin
          side_down_nxt = side_down_r | side_bit;
          if (side_down_nxt == 2'b11) begin
            evt.fire = 1'b1;
            evt.kind = EV_SIDE_COMBO;
          end
        end else if (enc_key) begin
          key_down_nxt = key_down_r | key_oh;
          stamp_we     = 1'b1;
          timer_on_nxt = timer_on_r | key_oh;
          // another key already down: cancel all holds
          if ((key_down_r & ~key_oh) != '0) begin
            timer_on_nxt = '0;
          end
          if (key_down_nxt[TOP_A] && key_down_nxt[TOP_B]) begin
            pair_top_nxt = 1'b1;
            evt.fire     = 1'b1;
            evt.kind     = EV_TOP_PAIR;
          end else if (key_down_nxt[BOT_A] && key_down_nxt[BOT_B]) begin
            pair_bot_nxt = 1'b1;
            evt.fire     = 1'b1;
            evt.kind     = EV_BOT_PAIR;
          end
        end
      end
      MODE_RELEASE: begin
        if (side_key) begin
          side_down_nxt = side_down_r & ~side_bit;
          if ((side_down_nxt & ~side_bit) == 2'b00) begin
            evt.fire  = 1'b1;
            evt.kind  = EV_SIDE_CLICK;
            evt.index = (req.key == KEY_RIGHT) ? IDX_W'(1) : IDX_W'(0);
          end
        end else if (enc_key) begin
          key_down_nxt = key_down_r & ~key_oh;
          timer_on_nxt = timer_on_r & ~key_oh;
          if ((held_r & key_oh) != '0) begin
            held_nxt = held_r & ~key_oh;
          end else if (pair_top_r && (req.key == KEY_W'(TOP_A)
                                      || req.key == KEY_W'(TOP_B))) begin
            pair_top_nxt = key_down_nxt[TOP_A] || key_down_nxt[TOP_B];
          end else if (pair_bot_r && (req.key == KEY_W'(BOT_A)
                                      || req.key == KEY_W'(BOT_B))) begin
            pair_bot_nxt = key_down_nxt[BOT_A] || key_down_nxt[BOT_B];
          end else begin
            evt.fire  = 1'b1;
            evt.kind  = EV_CLICK;
            evt.index = req.key[IDX_W-1:0];
          end
        end
      end
      MODE_TURN: begin
        if (enc_key) begin
          evt.fire   = 1'b1;
          evt.kind   = EV_TURN;
          evt.index  = req.key[IDX_W-1:0];
          evt.amount = req.amount;
        end
      end
      MODE_TICK: begin
        now_ms_nxt = now_inc;
        if (hold_due) begin
          timer_on_nxt[found] = 1'b0;
          held_nxt[found]     = 1'b1;
          evt.fire            = 1'b1;
          evt.kind            = EV_HOLD;
          evt.index           = IDX_W'(found);
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_down_r  <= '0;
      timer_on_r  <= '0;
      held_r      <= '0;
      pair_top_r  <= 1'b0;
      pair_bot_r  <= 1'b0;
      side_down_r <= 2'b00;
      now_ms_r    <= '0;
    end else if (go) begin
      key_down_r  <= key_down_nxt;
      timer_on_r  <= timer_on_nxt;
      held_r      <= held_nxt;
      pair_top_r  <= pair_top_nxt;
      pair_bot_r  <= pair_bot_nxt;
      side_down_r <= side_down_nxt;
      now_ms_r    <= now_ms_nxt;
    end
  end

  // Hold time register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_time_r <= HOLD_TIME_RST;
    end else if (cfg_wr_en) begin
      hold_time_r <= cfg_wr_data;
    end
  end

  // Press stamps; only read once a press has written them
  always_ff @(posedge clk) begin
    if (go && stamp_we) begin
      press_stamp_r[key_idx] <= now_ms_r;
    end
  end

endmodule

FILE: rtl/core/kgc_out_stage.sv
// Result register: holds one event until the consumer takes it.
module kgc_out_stage import kgc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    go,
  input  evt_t                    evt,
  output logic                    space,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [KIND_W-1:0]       out_event_kind,
  output logic [IDX_W-1:0]        out_event_index,
  output logic signed [AMT_W-1:0] out_event_amount
);

  logic out_valid_r, out_valid_nxt;
  evt_t evt_r;
  logic load;

  assign space = !out_valid_r || out_ready;
  assign load  = go && evt.fire;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      evt_r <= evt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = evt_r.kind;
  assign out_event_index  = evt_r.index;
  assign out_event_amount = evt_r.amount;

endmodule

FILE: rtl/core/kgc_checker.sv
// Port-level checker for the key gesture classifier, with its bind.
module kgc_checker import kgc_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [KIND_W-1:0]       out_event_kind,
  input logic [IDX_W-1:0]        out_event_index,
  input logic signed [AMT_W-1:0] out_event_amount
);

  // Stalled event holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_kind)
      && $stable(out_event_index) && $stable(out_event_amount))
    else $error("stalled event changed");

  // No event right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("event valid after reset");

  // Only turn events carry an amount
  a_amount_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind != EV_TURN |-> out_event_amount == '0)
    else $error("non-turn event with amount");

  // Combo and pair events have index zero; side clicks index 0 or 1
  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == EV_SIDE_COMBO || out_event_kind == EV_TOP_PAIR
      || out_event_kind == EV_BOT_PAIR || out_event_kind == EV_SIDE_CLICK)
    |-> out_event_index <= IDX_W'(1)
      && (out_event_kind == EV_SIDE_CLICK || out_event_index == '0))
    else $error("bad event index");

  // Intake is open whenever the output side is free
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && $past(!in_valid && rst_n) |-> in_ready)
    else $error("intake blocked while idle");

endmodule

bind key_gesture_classifier kgc_checker u_kgc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_event_kind   (out_event_kind),
  .out_event_index  (out_event_index),
  .out_event_amount (out_event_amount)
);

FILE: test/kgc_checker.sv
// Event checker for the key gesture classifier: tracks key state and compares every event.
`timescale 1ns / 1ps

module kgc_event_scoreboard import kgc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [HOLD_W-1:0]       cfg_wr_data,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [MODE_W-1:0]       in_mode,
  input  logic [KEY_W-1:0]        in_key,
  input  logic signed [AMT_W-1:0] in_turn_amount,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [KIND_W-1:0]       out_event_kind,
  input  logic [IDX_W-1:0]        out_event_index,
  input  logic signed [AMT_W-1:0] out_event_amount,
  output int                      fail_count,
  output int                      pending
);

  localparam int NK = NUM_KEYS_DEF;

  // Shadow copy of the classifier state
  logic [HOLD_W-1:0] hold_time;
  logic [NK-1:0]     keys_dn;
  logic [NK-1:0]     timers;
  logic [NK-1:0]     held;
  logic [TIME_W-1:0] stamp [NK];
  logic              top_pair;
  logic              bot_pair;
  logic [1:0]        side_dn;
  logic [TIME_W-1:0] now_ms;

  // Events predicted but not yet seen on the output
  evt_t gesture_q [$];

  // Work out the event, if any, that one request causes
  task automatic predict_gesture(input mode_t m, input logic [KEY_W-1:0] k,
                                 input logic signed [AMT_W-1:0] amt, output evt_t ev);
    logic              enc;
    logic              side;
    logic [NK-1:0]     kbit;
    logic [1:0]        sbit;
    logic [TIME_W-1:0] age;
    int                cnt;
    int                found;
    ev   = '0;
    enc  = (k < NK);
    side = (k == KEY_LEFT) || (k == KEY_RIGHT);
    kbit = enc ? (NK'(1) << k) : '0;
    sbit = (k == KEY_RIGHT) ? 2'b10 : 2'b01;
    case (m)
      MODE_PRESS: begin
        if (side) begin
          side_dn |= sbit;
          if (side_dn == 2'b11) begin
            ev.fire = 1'b1;
            ev.kind = EV_SIDE_COMBO;
          end
        end else if (enc) begin
          keys_dn  |= kbit;
          stamp[k]  = now_ms;
          timers   |= kbit;
          // a second key down cancels every hold timer
          if ((keys_dn & ~kbit) != '0) timers = '0;
          if (keys_dn[TOP_A] && keys_dn[TOP_B]) begin
            top_pair = 1'b1;
            ev.fire  = 1'b1;
            ev.kind  = EV_TOP_PAIR;
          end else if (keys_dn[BOT_A] && keys_dn[BOT_B]) begin
            bot_pair = 1'b1;
            ev.fire  = 1'b1;
            ev.kind  = EV_BOT_PAIR;
          end
        end
      end
      MODE_RELEASE: begin
        if (side) begin
          side_dn &= ~sbit;
          if ((side_dn & ~sbit) == 2'b00) begin
            ev.fire  = 1'b1;
            ev.kind  = EV_SIDE_CLICK;
            ev.index = (k == KEY_RIGHT) ? IDX_W'(1) : IDX_W'(0);
          end
        end else if (enc) begin
          keys_dn &= ~kbit;
          timers  &= ~kbit;
          if ((held & kbit) != '0) begin
            held &= ~kbit;
          end else if (top_pair && (k == TOP_A || k == TOP_B)) begin
            top_pair = keys_dn[TOP_A] || keys_dn[TOP_B];
          end else if (bot_pair && (k == BOT_A || k == BOT_B)) begin
            bot_pair = keys_dn[BOT_A] || keys_dn[BOT_B];
          end else begin
            ev.fire  = 1'b1;
            ev.kind  = EV_CLICK;
            ev.index = k[IDX_W-1:0];
          end
        end
      end
      MODE_TURN: begin
        if (enc) begin
          ev.fire   = 1'b1;
          ev.kind   = EV_TURN;
          ev.index  = k[IDX_W-1:0];
          ev.amount = amt;
        end
      end
      default: begin
        // tick: advance time, then test the highest running timer of a lone key
        now_ms = now_ms + 1'b1;
        cnt    = 0;
        found  = -1;
        for (int i = 0; i < NK; i++) begin
          cnt += keys_dn[i];
          if (timers[i]) found = i;
        end
        if (cnt == 1 && found >= 0) begin
          age = now_ms - stamp[found];
          if (age >= TIME_W'(hold_time)) begin
            timers[found] = 1'b0;
            held[found]   = 1'b1;
            ev.fire       = 1'b1;
            ev.kind       = EV_HOLD;
            ev.index      = IDX_W'(found);
          end
        end
      end
    endcase
  endtask

  task automatic report_fault(input string what, input evt_t want);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t %s: want kind %0d index %0d amount %0d, %s %0d index %0d amount %0d",
               $realtime, what, want.kind, want.index, want.amount, "got kind",
               out_event_kind, out_event_index, out_event_amount);
  endtask

  // Follow both channels at each edge
  always @(posedge clk) begin
    evt_t ev;
    evt_t want;
    if (!rst_n) begin
      hold_time  = HOLD_TIME_RST;
      keys_dn    = '0;
      timers     = '0;
      held       = '0;
      top_pair   = 1'b0;
      bot_pair   = 1'b0;
      side_dn    = 2'b00;
      now_ms     = '0;
      fail_count = 0;
      for (int i = 0; i < NK; i++) stamp[i] = '0;
      gesture_q.delete();
    end else begin
      if (cfg_wr_en) hold_time = cfg_wr_data;
      if (in_valid && in_ready) begin
        predict_gesture(mode_t'(in_mode), in_key, in_turn_amount, ev);
        if (ev.fire) gesture_q = {gesture_q, ev};
      end
      if (out_valid && out_ready) begin
        if (gesture_q.size() == 0) begin
          report_fault("unexpected event", '0);
        end else begin
          want = gesture_q.pop_front();
          if (out_event_kind != want.kind || out_event_index != want.index ||
              out_event_amount != want.amount)
            report_fault("event mismatch", want);
        end
      end
    end
    pending = gesture_q.size();
  end

endmodule

FILE: test/tb_key_gesture_classifier.sv
// Testbench top for the key gesture classifier: drives gestures and reports the verdict.
`timescale 1ns / 1ps

module tb_key_gesture_classifier import kgc_pkg::*;;

  localparam int NK         = NUM_KEYS_DEF;
  localparam int LONG_STALL = 300;
  localparam int STUCK_MAX  = 4000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                    cfg_wr_en      = 1'b0;
  logic [HOLD_W-1:0]       cfg_wr_data    = '0;
  logic                    in_valid       = 1'b0;
  logic                    in_ready;
  logic [MODE_W-1:0]       in_mode        = '0;
  logic [KEY_W-1:0]        in_key         = '0;
  logic signed [AMT_W-1:0] in_turn_amount = '0;
  logic                    out_valid;
  logic                    out_ready      = 1'b0;
  logic [KIND_W-1:0]       out_event_kind;
  logic [IDX_W-1:0]        out_event_index;
  logic signed [AMT_W-1:0] out_event_amount;

  int fail_count;
  int pending;

  // Pacing knobs and run state; send_idle and recv_idle in percent of cycles spent idle
  int send_idle     = 0;
  int recv_idle     = 0;
  int stall_asks    = 0;
  int stall_done    = 0;
  int stall_left    = 0;
  int hold_setting  = HOLD_TIME_RST;
  int gesture_items = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  key_gesture_classifier #(.NUM_KEYS(NUM_KEYS_DEF)) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_key          (in_key),
    .in_turn_amount  (in_turn_amount),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_kind  (out_event_kind),
    .out_event_index (out_event_index),
    .out_event_amount(out_event_amount)
  );

  kgc_event_scoreboard gesture_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_key          (in_key),
    .in_turn_amount  (in_turn_amount),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_kind  (out_event_kind),
    .out_event_index (out_event_index),
    .out_event_amount(out_event_amount),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // Event receiver: random back-pressure, or a long hold-off on request
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_done != stall_asks) begin
      out_ready  <= 1'b0;
      stall_left <= LONG_STALL;
      stall_done <= stall_done + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Watchdog: too many cycles with no transfer on either channel
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_MAX) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stuck = 0;
      else stuck++;
    end
    $display("status: fail");
    $finish;
  end

  // Offer one request and hold it until it is taken
  task automatic send_req(input mode_t m, input int k, input int amt);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= m;
    in_key         <= KEY_W'(k);
    in_turn_amount <= AMT_W'(amt);
    if (m == MODE_TICK || k <= KEY_RIGHT) gesture_items++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_ticks(input int n);
    for (int i = 0; i < n; i++) send_req(MODE_TICK, $urandom_range(0, 15), $urandom);
  endtask

  // Stop sending until every predicted event is out and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_hold(input int v);
    cfg_wr_en    <= 1'b1;
    cfg_wr_data  <= HOLD_W'(v);
    hold_setting  = v;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
  endtask

  task automatic release_all();
    for (int k = 0; k <= KEY_RIGHT; k++) send_req(MODE_RELEASE, k, $urandom);
  endtask

  // Random gestures, mostly well formed, with some noise mixed in
  task automatic run_gestures(input int target);
    int start;
    int pick;
    int k;
    int k2;
    int a;
    int b;
    start = gesture_items;
    while (gesture_items - start < target) begin
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, NK - 1);
      if (pick < 18) begin
        // click
        send_req(MODE_PRESS, k, $urandom);
        send_ticks($urandom_range(0, 2));
        send_req(MODE_RELEASE, k, $urandom);
      end else if (pick < 38) begin
        // hold, sometimes spoiled by a second key
        send_req(MODE_PRESS, k, $urandom);
        if ($urandom_range(0, 3) == 0) begin
          k2 = $urandom_range(0, NK - 1);
          send_req(MODE_PRESS, k2, $urandom);
          send_req(MODE_RELEASE, k2, $urandom);
        end
        send_ticks($urandom_range(0, hold_setting + 2));
        send_req(MODE_RELEASE, k, $urandom);
      end else if (pick < 58) begin
        // top or bottom pair, either order
        if (pick < 48) begin
          a = TOP_A;
          b = TOP_B;
        end else begin
          a = BOT_A;
          b = BOT_B;
        end
        if ($urandom_range(0, 1)) begin
          k2 = a;
          a  = b;
          b  = k2;
        end
        send_req(MODE_PRESS, a, $urandom);
        send_req(MODE_PRESS, b, $urandom);
        send_ticks($urandom_range(0, 2));
        if ($urandom_range(0, 1)) begin
          send_req(MODE_RELEASE, a, $urandom);
          send_req(MODE_RELEASE, b, $urandom);
        end else begin
          send_req(MODE_RELEASE, b, $urandom);
          send_req(MODE_RELEASE, a, $urandom);
        end
      end else if (pick < 68) begin
        // side keys, alone or together
        a = $urandom_range(0, 1) ? int'(KEY_LEFT) : int'(KEY_RIGHT);
        b = int'(KEY_LEFT) + int'(KEY_RIGHT) - a;
        if ($urandom_range(0, 3) != 0) send_req(MODE_PRESS, a, $urandom);
        if ($urandom_range(0, 1)) send_req(MODE_PRESS, b, $urandom);
        send_req(MODE_RELEASE, a, $urandom);
        send_req(MODE_RELEASE, b, $urandom);
      end else if (pick < 78) begin
        send_req(MODE_TURN, $urandom_range(0, 15), $urandom);
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 4))
          send_req(mode_t'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom);
      end else begin
        release_all();
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default hold time: a lone key fires on the 500th tick
    send_req(MODE_PRESS, 1, 0);
    send_ticks(HOLD_TIME_RST);
    send_req(MODE_RELEASE, 1, 0);
    drain();

    // Directed cases with zero hold time
    write_hold(0);
    send_idle = 25;
    recv_idle = 51;
    send_req(MODE_PRESS, 0, 0);
    send_req(MODE_TICK, 15, -1);
    send_req(MODE_RELEASE, 0, 0);
    // second key cancels the hold timers
    send_req(MODE_PRESS, 1, 0);
    send_req(MODE_PRESS, 4, 0);
    send_req(MODE_TICK, 0, 0);
    send_req(MODE_RELEASE, 4, 0);
    send_req(MODE_TICK, 0, 0);
    send_req(MODE_RELEASE, 1, 0);
    // top pair masks the bottom pair; top members give no click, bottom members do
    send_req(MODE_PRESS, TOP_A, 0);
    send_req(MODE_PRESS, TOP_B, 0);
    send_req(MODE_PRESS, BOT_A, 0);
    send_req(MODE_PRESS, BOT_B, 0);
    send_req(MODE_RELEASE, TOP_A, 0);
    send_req(MODE_RELEASE, TOP_B, 0);
    send_req(MODE_RELEASE, BOT_A, 0);
    send_req(MODE_RELEASE, BOT_B, 0);
    // side combination then side click
    send_req(MODE_PRESS, KEY_LEFT, 0);
    send_req(MODE_PRESS, KEY_RIGHT, 0);
    send_req(MODE_RELEASE, KEY_LEFT, 0);
    send_req(MODE_RELEASE, KEY_RIGHT, 0);
    // turn extremes and ignored keys
    send_req(MODE_TURN, 0, -128);
    send_req(MODE_TURN, NK - 1, 127);
    send_req(MODE_TURN, 15, 'h55);
    send_req(MODE_PRESS, 15, 0);
    send_req(MODE_RELEASE, 9, 0);
    // release of a key that is already up
    send_req(MODE_RELEASE, 4, 0);
    drain();

    // Sender idles a quarter, receiver half; one long receiver hold-off
    write_hold(1);
    run_gestures(60);
    stall_asks++;
    run_gestures(60);
    drain();

    // Roles swapped; sender pauses once for the pipe to empty
    write_hold($urandom_range(2, 12));
    send_idle = 51;
    recv_idle = 25;
    run_gestures(60);
    drain();
    run_gestures(60);
    drain();

    // No idling at all
    write_hold($urandom_range(3, 8));
    send_idle = 0;
    recv_idle = 0;
    run_gestures(120);
    release_all();
    drain();

    // Longest hold time: a short press never reaches it
    write_hold(65535);
    send_req(MODE_PRESS, NK - 1, 0);
    send_ticks(20);
    send_req(MODE_RELEASE, NK - 1, 0);
    drain();

    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
